/* rtl/sliding_median_five_filter_core_macros.svh */
// assertion macros for the sliding median filter
`ifndef SLIDING_MEDIAN_FIVE_FILTER_CORE_MACROS_SVH
`define SLIDING_MEDIAN_FIVE_FILTER_CORE_MACROS_SVH

// checked only outside reset
`define SMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/smf_pkg.sv */
package smf_pkg;

  localparam int WINDOW_LEN  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int AGE_BITS    = $clog2(WINDOW_LEN);
  localparam int MID_IDX     = (WINDOW_LEN - 1) / 2;
  localparam int NEG_CNT     = (WINDOW_LEN + 1) / 2;
  localparam int RESET_MAG   = 99 * 256;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0] age_t;

  // compressed entry handed from a cell to the one above it
  typedef struct packed {
    logic    lt;
    logic    past_old;
    sample_t val;
    age_t    age;
  } link_t;

  // reset window, sorted: the negative entries below the positive ones
  function automatic sample_t reset_val(int idx);
    logic signed [31:0] w;
    w = (idx < NEG_CNT) ? -32'(RESET_MAG) : 32'(RESET_MAG);
    return w[SAMPLE_BITS-1:0];
  endfunction

  // age of a reset entry follows its ring slot; slot 0 is the oldest
  function automatic age_t reset_age(int idx);
    int k;
    k = (idx < NEG_CNT) ? 2 * idx : 2 * (idx - NEG_CNT) + 1;
    return AGE_BITS'(WINDOW_LEN - 1 - k);
  endfunction

endpackage

/* rtl/sliding_median_five_filter_core.sv */
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle; the whole cell row updates together for each
// item; a held result blocks the input until it is taken, the next item going in that cycle
// reset (synchronous, rst_n low): result valid cleared, window loaded with
// -99, 99, -99, 99, -99 degrees in q8.8, the oldest entry being the first -99
module sliding_median_five_filter_core
  import smf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_median
);

  // the window is kept sorted ascending across the cell row, each cell
  // holding one entry and its age; the entry with the top age is the oldest
  // one and leaves when a new item comes in

  logic    accept;
  logic    out_valid_r;
  logic    out_valid_nxt;
  sample_t out_median_r;
  sample_t out_median_nxt;

  link_t   links    [WINDOW_LEN+1];
  sample_t cell_val [WINDOW_LEN];
  age_t    cell_age [WINDOW_LEN];
  sample_t cell_nxt [WINDOW_LEN];

  // output register frees the input side as soon as the result is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // bottom of the chain: the new item goes in at the lowest slot that fits
  assign links[0].lt       = 1'b1;
  assign links[0].past_old = 1'b0;
  assign links[0].val      = '0;
  assign links[0].age      = '0;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    sample_t up_val;
    age_t    up_age;

    // the top cell has no upper neighbor; its own entry stands in
    if (i == WINDOW_LEN - 1) begin : g_top
      assign up_val = cell_val[i];
      assign up_age = cell_age[i];
    end else begin : g_mid
      assign up_val = cell_val[i+1];
      assign up_age = cell_age[i+1];
    end

    smf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (accept),
      .top_cell   (i == WINDOW_LEN - 1),
      .rst_val    (reset_val(i)),
      .rst_age    (reset_age(i)),
      .new_sample (in_sample),
      .up_val     (up_val),
      .up_age     (up_age),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .val        (cell_val[i]),
      .age        (cell_age[i]),
      .val_nxt    (cell_nxt[i])
    );
  end

  // median is the middle cell of the updated sorted row
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = cell_nxt[MID_IDX];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    out_median_r <= out_median_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

/* rtl/smf_cell.sv */
module smf_cell
  import smf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    top_cell,
  input  sample_t rst_val,
  input  age_t    rst_age,
  input  sample_t new_sample,
  input  sample_t up_val,
  input  age_t    up_age,
  input  link_t   link_in,
  output link_t   link_out,
  output sample_t val,
  output age_t    age,
  output sample_t val_nxt
);

  sample_t val_r;
  age_t    age_r;
  age_t    age_nxt;
  logic    old_here;
  logic    past_old;
  sample_t c_val;
  age_t    c_age;
  logic    lt;

  assign old_here = (age_r == AGE_BITS'(WINDOW_LEN - 1));
  assign past_old = link_in.past_old | old_here;

  // drop the oldest entry: cells at or above it take the upper neighbor
  assign c_val = past_old ? up_val : val_r;
  assign c_age = past_old ? up_age : age_r;
  assign lt    = !top_cell && (c_val < new_sample);

  always_comb begin
    if (lt) begin
      val_nxt = c_val;
      age_nxt = c_age + 1'b1;
    end else if (link_in.lt) begin
      val_nxt = new_sample;
      age_nxt = '0;
    end else begin
      val_nxt = link_in.val;
      age_nxt = link_in.age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= rst_val;
      age_r <= rst_age;
    end else if (load) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign link_out.lt       = lt;
  assign link_out.past_old = past_old;
  assign link_out.val      = c_val;
  assign link_out.age      = c_age;
  assign val = val_r;
  assign age = age_r;

endmodule

/* rtl/smf_checker.sv */
`include "sliding_median_five_filter_core_macros.svh"

module smf_checker
  import smf_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_median
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `SMF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")
  `SMF_ASSERT(a_item_gives_result, in_acc |=> out_valid, "accepted item gave no result")
  `SMF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result held")
  `SMF_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(out_median), "stalled result changed")

endmodule

bind sliding_median_five_filter_core smf_checker u_smf_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import smf_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;

  // tracks the sample ring and the medians still owed by the filter
  class median_tracker;
    sample_t ring [WINDOW_LEN];
    int unsigned slot;
    sample_t expected_medians [$];
    int mismatches;
    int orphans;
    int checked;

    function new();
      // reset window alternates -99 / +99 degrees, starting with -99 in slot 0
      for (int k = 0; k < WINDOW_LEN; k++) begin
        ring[k] = (k % 2 == 1) ? sample_t'(RESET_MAG) : sample_t'(-RESET_MAG);
      end
      slot = 0;
      mismatches = 0;
      orphans = 0;
      checked = 0;
    endfunction

    // overwrite the oldest entry, then queue the median of the window
    function void note_sample(sample_t s);
      sample_t sorted [WINDOW_LEN];
      sample_t t;
      int j;
      ring[slot] = s;
      slot = (slot + 1) % WINDOW_LEN;
      sorted = ring;
      // insertion sort; ties do not change the middle value
      for (int i = 1; i < WINDOW_LEN; i++) begin
        t = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > t) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = t;
      end
      expected_medians.push_back(sorted[MID_IDX]);
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (expected_medians.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= MAX_REPORTS)
          $display("unexpected median %0d with no item pending", got);
        return;
      end
      want = expected_medians.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches + orphans <= MAX_REPORTS)
          $display("median mismatch at result %0d: expected %0d, got %0d",
                   checked, want, got);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_median;

  median_tracker tracker;
  int samples_taken = 0;
  int held_results = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;
  int rx_mode = 0;
  int rx_count = 0;

  // full-scale values, the reset levels, ties and monotonic runs
  int directed_set [24] = '{
    -32768, 32767, 32767, -32768, 0,
    -1, 1, 0, 0, 0,
    0, 0, 25344, -25344, 21845,
    -21846, 100, 200, 300, 400,
    500, 400, 300, -32768
  };

  sliding_median_five_filter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // handshake monitor: values seen here are the ones before this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_sample(in_sample);
        samples_taken++;
      end
      if (out_valid && out_ready)
        tracker.check_median(out_median);
      if (out_valid && !out_ready)
        held_results++;
    end
  end

  // receiver back-pressure: modes are redrawn when the hold counter runs out
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_count <= $urandom_range(16, 96);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (rx_count % 4 != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // one item; valid stays high across a burst, drops only for a real gap
  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sample_t s;
    sample_t prev;
    int base;
    tracker = new();
    prev = '0;
    base = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_set[i]) send_sample(sample_t'(directed_set[i]));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
        base = int'($urandom_range(0, 60000)) - 30000;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = sample_t'($urandom);
        // slowly varying readings around a level, lots of near-ties
        4, 5, 6: s = sample_t'(base + int'($urandom_range(0, 16)) - 8);
        7: begin
          case ($urandom_range(0, 3))
            0: s = sample_t'(-32768);
            1: s = sample_t'(32767);
            2: s = '0;
            default: s = sample_t'(-1);
          endcase
        end
        default: s = prev;
      endcase
      prev = s;
      send_sample(s);
    end
    in_valid <= 1'b0;

    while (tracker.expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run fed %0d samples (%0d directed, %0d random), checked %0d medians",
             samples_taken, $size(directed_set), RANDOM_ITEMS, tracker.checked);
    $display("results held by back-pressure: %0d cycles; mismatches %0d, unexpected %0d",
             held_results, tracker.mismatches, tracker.orphans);
    if (tracker.mismatches == 0 && tracker.orphans == 0 &&
        tracker.expected_medians.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
